>>> rtl/lru_keyed_cache_policy_core_assert.svh
// Assertion macros shared by the cache policy core.
`ifndef LRU_KEYED_CACHE_POLICY_CORE_ASSERT_SVH
`define LRU_KEYED_CACHE_POLICY_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("lkcp assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LKCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("lkcp assertion failed");

`endif

>>> rtl/lkcp_pkg.sv
`default_nettype none

package lkcp_pkg;

    localparam int DEPTH_DEF  = 128;
    localparam int KEY_W_DEF  = 32;

    localparam int IN_KEY_W   = 32;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 7;
    localparam int OCC_W      = 8;
    localparam int CAP_W      = 8;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    localparam logic [STATUS_W-1:0] ST_HIT  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    typedef struct packed {
        logic [IN_KEY_W-1:0] key;
        logic                open_ok;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                evicted;
        logic [IN_KEY_W-1:0] evicted_key;
        logic [OCC_W-1:0]    occupancy;
    } t_out;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
        logic upd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic pass_done;
        logic need_upd;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

>>> rtl/lkcp_ctrl.sv
`default_nettype none

module lkcp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lkcp_pkg::t_sts i_sts,
    output lkcp_pkg::t_cmd o_cmd,
    output logic          o_in_stall
);
    import lkcp_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_COMMIT = 3'd2;
    localparam logic [2:0] S_UPD    = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.pass_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                n_state = i_sts.need_upd ? S_UPD : S_DONE;
            end
            S_UPD: begin
                if (i_sts.pass_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.commit = (r_state == S_COMMIT);
        o_cmd.upd    = (r_state == S_UPD);
        o_cmd.emit   = (r_state == S_DONE) && i_sts.out_free;
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

`default_nettype wire

>>> rtl/lkcp_dp.sv
`default_nettype none

module lkcp_dp #(
    parameter int DEPTH     = lkcp_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = lkcp_pkg::KEY_W_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lkcp_pkg::t_cmd             i_cmd,
    output lkcp_pkg::t_sts             o_sts,
    input  lkcp_pkg::t_in              i_in_data,
    input  logic [lkcp_pkg::CAP_W-1:0] i_capacity,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output lkcp_pkg::t_out             o_out_data
);
    import lkcp_pkg::*;

    localparam int IW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    logic [KEY_WIDTH-1:0] r_key_mem [DEPTH];
    logic [IW-1:0]        r_rank_mem [DEPTH];
    logic [KEY_WIDTH-1:0] r_key_q;
    logic [IW-1:0]        r_rank_q;

    logic [DEPTH-1:0]     r_valid;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;

    logic [IW:0]          r_cnt;
    logic                 r_pend;
    logic [IW-1:0]        r_pidx;

    logic [KEY_WIDTH-1:0] r_key;
    logic                 r_ok;
    logic                 r_hit_f;
    logic [IW-1:0]        r_hit_idx;
    logic [IW-1:0]        r_hit_rank;
    logic                 r_vic_f;
    logic [IW-1:0]        r_vic_idx;
    logic [IW-1:0]        r_vic_rank;
    logic [KEY_WIDTH-1:0] r_vic_key;
    logic                 r_free_f;
    logic [IW-1:0]        r_free_idx;

    logic                 r_upd_hit;
    logic [IW-1:0]        r_tgt;
    t_out                 r_res;
    logic                 r_out_vld;
    t_out                 r_out;

    logic                 pass_on;
    logic                 rd_en;
    logic                 cur_v;
    logic [CMPW-1:0]      cap_w;
    logic [CMPW-1:0]      eff_cap;
    logic                 full;
    logic                 evict;
    logic                 use_vic;
    logic                 insert;
    logic [IW-1:0]        ins_idx;
    logic                 upd_we;
    logic [IW-1:0]        upd_val;

    assign pass_on = i_cmd.scan || i_cmd.upd;
    assign rd_en   = pass_on && (r_cnt != (IW+1)'(DEPTH));
    assign cur_v   = r_valid[r_pidx];

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_key_q  <= r_key_mem[r_cnt[IW-1:0]];
            r_rank_q <= r_rank_mem[r_cnt[IW-1:0]];
        end
        if (i_cmd.commit && insert) begin
            r_key_mem[ins_idx] <= r_key;
        end
        if (upd_we) begin
            r_rank_mem[r_pidx] <= upd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.load || i_cmd.commit) begin
            r_cnt  <= '0;
            r_pend <= 1'b0;
        end else if (rd_en) begin
            r_cnt  <= r_cnt + 1'b1;
            r_pend <= 1'b1;
            r_pidx <= r_cnt[IW-1:0];
        end else begin
            r_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= KEY_WIDTH'(i_in_data.key);
            r_ok     <= i_in_data.open_ok;
            r_hit_f  <= 1'b0;
            r_vic_f  <= 1'b0;
            r_free_f <= 1'b0;
        end else if (i_cmd.scan && r_pend) begin
            if (cur_v && (r_key_q == r_key) && !r_hit_f) begin
                r_hit_f    <= 1'b1;
                r_hit_idx  <= r_pidx;
                r_hit_rank <= r_rank_q;
            end
            if (cur_v && (!r_vic_f || (r_rank_q > r_vic_rank))) begin
                r_vic_f    <= 1'b1;
                r_vic_idx  <= r_pidx;
                r_vic_rank <= r_rank_q;
                r_vic_key  <= r_key_q;
            end
            if (!cur_v && !r_free_f) begin
                r_free_f   <= 1'b1;
                r_free_idx <= r_pidx;
            end
        end
    end

    always_comb begin
        cap_w = CMPW'(i_capacity);
        if (cap_w == '0) begin
            eff_cap = CMPW'(1);
        end else if (cap_w > CMPW'(DEPTH)) begin
            eff_cap = CMPW'(DEPTH);
        end else begin
            eff_cap = cap_w;
        end
        full    = (CMPW'(r_count) >= eff_cap) && (r_count != '0);
        evict   = !r_hit_f && full && r_vic_f;
        use_vic = evict && (!r_free_f || (r_vic_idx < r_free_idx));
        ins_idx = use_vic ? r_vic_idx : r_free_idx;
        insert  = !r_hit_f && r_ok && (r_free_f || evict);
        n_count = r_count - CW'(evict) + CW'(insert);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (evict && !(insert && use_vic)) begin
                r_valid[r_vic_idx] <= 1'b0;
            end
            if (insert) begin
                r_valid[ins_idx] <= 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_upd_hit         <= r_hit_f;
            r_tgt             <= r_hit_f ? r_hit_idx : ins_idx;
            r_res.status      <= r_hit_f ? ST_HIT : (insert ? ST_INS : ST_FAIL);
            r_res.slot        <= r_hit_f ? SLOT_W'(r_hit_idx)
                                         : (insert ? SLOT_W'(ins_idx) : '0);
            r_res.evicted     <= evict;
            r_res.evicted_key <= evict ? IN_KEY_W'(r_vic_key) : '0;
            r_res.occupancy   <= OCC_W'(n_count);
        end
    end

    always_comb begin
        upd_we  = 1'b0;
        upd_val = '0;
        if (i_cmd.upd && r_pend) begin
            if (r_pidx == r_tgt) begin
                upd_we = 1'b1;
            end else if (cur_v && (!r_upd_hit || (r_rank_q < r_hit_rank))) begin
                upd_we  = 1'b1;
                upd_val = r_rank_q + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_comb begin
        o_sts.pass_done = r_pend && (r_pidx == IW'(DEPTH - 1));
        o_sts.need_upd  = r_hit_f || insert;
        o_sts.out_free  = !r_out_vld || !i_out_stall;
    end

endmodule

`default_nettype wire

>>> rtl/lru_keyed_cache_policy_core.sv
`default_nettype none
`include "lru_keyed_cache_policy_core_assert.svh"

// Fully associative cache of DEPTH keyed entries with least-recently-used
// replacement. Each item carries a key and an open_ok flag and yields one
// result: a hit moves the entry to most recent, a miss on a full cache evicts
// the least recent entry, and a miss with open_ok set inserts the key as most
// recent in the lowest free slot. With the output free, the next item can be
// accepted once the result is emitted after the rank pass, or after the
// commit on a miss that inserts nothing; the result reaches the output as
// the core returns to idle. A first pass over the key and rank tables finds
// the hit, the victim and the free slot, a commit step records the outcome,
// and a second pass rewrites the recency ranks, reading one slot per cycle
// and writing back the slot read in the cycle before. The next item is
// taken while the previous result waits at the output. The capacity
// register answers at APB addresses 0 to 3, where paddr[2] is clear.
module lru_keyed_cache_policy_core #(
    parameter int DEPTH     = lkcp_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH = lkcp_pkg::KEY_W_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  lkcp_pkg::t_in               i_in_data,
    output logic                        o_in_stall,
    output logic                        o_out_valid,
    output lkcp_pkg::t_out              o_out_data,
    input  logic                        i_out_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lkcp_pkg::APB_AW-1:0] paddr,
    input  logic [lkcp_pkg::APB_DW-1:0] pwdata,
    output logic [lkcp_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);
    import lkcp_pkg::*;

    localparam logic REG_CAPACITY = 1'b0;

    logic [CAP_W-1:0] r_capacity;
    logic             cfg_wr;
    t_cmd             cmd;
    t_sts             sts;
    logic [4:0]       cmd_bits;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && (paddr[2] == REG_CAPACITY)) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(r_capacity) : '0;

    lkcp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    lkcp_dp #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_capacity  (r_capacity),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    assign cmd_bits = cmd;

    `LKCP_ASSERT_NOW(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(cmd_bits))
    `LKCP_ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    `LKCP_ASSERT_NOW(a_hit_no_evict, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_HIT), !o_out_data.evicted)
    `LKCP_ASSERT_NOW(a_fail_slot_zero, i_clk, i_rst_n, o_out_valid && (o_out_data.status == ST_FAIL), o_out_data.slot == '0)

endmodule

`default_nettype wire

>>> tb/sv/lru_keyed_cache_policy_core_tb.sv
`timescale 1ns / 1ps

module lru_keyed_cache_policy_core_tb;

    import lkcp_pkg::*;

    localparam int DEPTH = DEPTH_DEF;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
    localparam int QUIET_LIMIT = 4000;
    localparam logic [APB_AW-1:0] ADDR_CAPACITY = 3'd0;
    localparam logic [APB_AW-1:0] ADDR_SPARE = 3'd4;

    class lru_tracker;
        bit [IN_KEY_W-1:0] keys[DEPTH];
        bit used[DEPTH];
        int rank[DEPTH];
        int count;
        bit [CAP_W-1:0] capacity;
        t_out predicted_results[$];
        int errors;

        function new();
            foreach (used[i]) begin
                used[i] = 1'b0;
                rank[i] = 0;
                keys[i] = '0;
            end
            count = 0;
            capacity = CAP_RESET;
            errors = 0;
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction

        function void set_capacity(bit [CAP_W-1:0] value);
            capacity = value;
        endfunction

        task report(string msg);
            if (errors < 50) begin
                $display("[%0t] %s", $realtime, msg);
            end
            errors++;
        endtask

        function void note_request(t_in item);
            t_out res;
            int hit;
            int victim;
            int best;
            int free_slot;
            int cap;
            res = '0;
            hit = -1;
            for (int i = 0; i < DEPTH; i++) begin
                if (used[i] && keys[i] == item.key) begin
                    hit = i;
                    break;
                end
            end
            if (hit >= 0) begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (used[i] && rank[i] < rank[hit]) begin
                        rank[i]++;
                    end
                end
                rank[hit] = 0;
                res.status = ST_HIT;
                res.slot = SLOT_W'(hit);
            end else begin
                cap = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : int'(capacity));
                if (count >= cap && count > 0) begin
                    victim = -1;
                    best = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (used[i] && (victim < 0 || rank[i] > best)) begin
                            victim = i;
                            best = rank[i];
                        end
                    end
                    if (victim >= 0) begin
                        used[victim] = 1'b0;
                        count--;
                        res.evicted = 1'b1;
                        res.evicted_key = keys[victim];
                    end
                end
                res.status = ST_FAIL;
                if (item.open_ok) begin
                    free_slot = -1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (!used[i]) begin
                            free_slot = i;
                            break;
                        end
                    end
                    if (free_slot >= 0) begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (used[i]) begin
                                rank[i]++;
                            end
                        end
                        used[free_slot] = 1'b1;
                        keys[free_slot] = item.key;
                        rank[free_slot] = 0;
                        count++;
                        res.status = ST_INS;
                        res.slot = SLOT_W'(free_slot);
                    end
                end
            end
            res.occupancy = OCC_W'(count);
            predicted_results.push_back(res);
        endfunction

        task check_result(t_out got);
            t_out want;
            if (predicted_results.size() == 0) begin
                report($sformatf("result with no item pending: st=%0d slot=%0d ev=%0d evk=%h occ=%0d",
                                 got.status, got.slot, got.evicted, got.evicted_key,
                                 got.occupancy));
            end else begin
                want = predicted_results.pop_front();
                if (got.status !== want.status || got.slot !== want.slot ||
                    got.evicted !== want.evicted || got.evicted_key !== want.evicted_key ||
                    got.occupancy !== want.occupancy) begin
                    report($sformatf({"result mismatch: got st=%0d slot=%0d ev=%0d evk=%h ",
                                      "occ=%0d, want st=%0d slot=%0d ev=%0d evk=%h occ=%0d"},
                                     got.status, got.slot, got.evicted, got.evicted_key,
                                     got.occupancy, want.status, want.slot, want.evicted,
                                     want.evicted_key, want.occupancy));
                end
            end
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    t_in                 i_in_data;
    logic                o_in_stall;
    logic                o_out_valid;
    t_out                o_out_data;
    logic                i_out_stall;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    lru_tracker tracker;
    bit idle_en;
    int stall_left;
    int quiet_cycles;

    lru_keyed_cache_policy_core dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in_data(i_in_data),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out_data(o_out_data),
        .i_out_stall(i_out_stall),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
            quiet_cycles = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                tracker.check_result(o_out_data);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (stall_left > 0) begin
                stall_left--;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 16);
            end
            i_out_stall <= (stall_left != 0);
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("FAIL lru_keyed_cache_policy_core");
                $finish;
            end
        end
    end

    task automatic send_item(bit [IN_KEY_W-1:0] key, bit ok);
        t_in item;
        item.key = key;
        item.open_ok = ok;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.note_request(item);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [APB_AW-1:0] addr, logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_CAPACITY) begin
            tracker.set_capacity(data[CAP_W-1:0]);
        end
    endtask

    task automatic set_capacity(int cap);
        wait_idle();
        apb_write(ADDR_CAPACITY, {24'($urandom_range(0, 16777215)), 8'(cap)});
    endtask

    task automatic run_phase(int cap, int pool_n, int n_items);
        bit [IN_KEY_W-1:0] pool[$];
        bit [IN_KEY_W-1:0] key;
        set_capacity(cap);
        repeat (pool_n) pool.push_back($urandom);
        repeat (n_items) begin
            if ($urandom_range(0, 6) != 0) begin
                key = pool[$urandom_range(0, pool_n - 1)];
            end else begin
                key = $urandom;
            end
            send_item(key, $urandom_range(0, 4) != 0);
        end
    endtask

    initial begin
        tracker = new();
        idle_en = 1'b0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_idle();
        apb_write(ADDR_SPARE, 32'hFFFF_FFFF);

        send_item(32'h0000_0000, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);
        send_item(32'h0000_0000, 1'b0);
        send_item(32'hAAAA_AAAA, 1'b0);

        set_capacity(2);
        send_item(32'h5555_5555, 1'b1);
        send_item(32'h1234_5678, 1'b0);
        send_item(32'h5555_5555, 1'b0);
        send_item(32'h0000_0000, 1'b1);
        send_item(32'hFFFF_FFFF, 1'b1);

        set_capacity(0);
        send_item(32'h0000_0001, 1'b1);
        send_item(32'h0000_0002, 1'b1);
        send_item(32'h0000_0002, 1'b1);
        send_item(32'h0000_0003, 1'b0);
        send_item(32'h0000_0004, 1'b0);
        send_item(32'h0000_0005, 1'b0);

        set_capacity(255);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'h7FFF_FFFF, 1'b1);
        send_item(32'h8000_0000, 1'b1);
        send_item(32'hCAFE_F00D, 1'b0);

        idle_en = 1'b1;
        run_phase(255, 160, 400);
        run_phase(3, 6, 150);
        run_phase(1, 3, 100);
        run_phase(128, 140, 300);
        run_phase(100, 120, 250);
        run_phase($urandom_range(1, 128), $urandom_range(2, 150), 200);
        wait_idle();
        idle_en = 1'b0;
        run_phase(8, 12, 100);
        wait_idle();

        if (tracker.errors == 0) begin
            $display("PASS lru_keyed_cache_policy_core");
        end else begin
            $display("FAIL lru_keyed_cache_policy_core");
        end
        $finish;
    end

endmodule
